@@ rtl/core/ham_palette_pixel_decoder_assert.svh @@
// Assertion macros used by the checker file of the HAM pixel decoder.
`ifndef HAM_PALETTE_PIXEL_DECODER_ASSERT_SVH
`define HAM_PALETTE_PIXEL_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HAM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ham decoder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HAM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ham decoder check failed");

`endif

@@ rtl/core/ham_pd_pkg.sv @@
// Types, constants and register map of the HAM palette pixel decoder.
package ham_pd_pkg;

    // Palette size and queue depth.
    localparam int PD_TABLE_ENTRIES = 256;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_CNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_HAM_ENABLE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PLANE_DEPTH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RED_SHIFT   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_GREEN_SHIFT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLUE_SHIFT  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA_SHIFT = 3'd5;

    // Register reset values.
    localparam logic       RST_HAM_ENABLE  = 1'b0;
    localparam logic [3:0] RST_PLANE_DEPTH = 4'd6;
    localparam logic [4:0] RST_RED_SHIFT   = 5'd16;
    localparam logic [4:0] RST_GREEN_SHIFT = 5'd8;
    localparam logic [4:0] RST_BLUE_SHIFT  = 5'd0;
    localparam logic [4:0] RST_ALPHA_SHIFT = 5'd24;

    // Usable range of the plane depth.
    localparam logic [3:0] DEPTH_MIN = 4'd3;
    localparam logic [3:0] DEPTH_MAX = 4'd8;

    // Input function codes.
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    // Hold-and-modify control codes in the top two of the used pixel bits.
    localparam logic [1:0] HAM_MODE_LOOKUP = 2'h0;
    localparam logic [1:0] HAM_MODE_BLUE   = 2'h1;
    localparam logic [1:0] HAM_MODE_RED    = 2'h2;
    localparam logic [1:0] HAM_MODE_GREEN  = 2'h3;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic       ham_enable;
        logic [3:0] plane_depth;
        logic [4:0] red_shift;
        logic [4:0] green_shift;
        logic [4:0] blue_shift;
        logic [4:0] alpha_shift;
    } ham_cfg_t;

    // Classified pixel operation handed from front to back.
    typedef struct packed {
        logic [1:0] mode;
        logic       line_start;
        logic [7:0] val;
    } ham_op_t;

    // Queue entry: operation plus the palette word read for it.
    typedef struct packed {
        ham_op_t     op;
        logic [31:0] rdata;
    } ham_entry_t;

endpackage

@@ rtl/core/ham_pd_if.sv @@
// Channel interfaces of the HAM palette pixel decoder.

// Input item channel.
interface ham_pd_item_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic       line_start;
    logic [7:0] pixel_value;
    logic [7:0] entry_index;
    logic [7:0] entry_red;
    logic [7:0] entry_green;
    logic [7:0] entry_blue;
    logic [7:0] entry_alpha;

    modport source (
        output valid, func, line_start, pixel_value, entry_index,
               entry_red, entry_green, entry_blue, entry_alpha,
        input  ready
    );
    modport sink (
        input  valid, func, line_start, pixel_value, entry_index,
               entry_red, entry_green, entry_blue, entry_alpha,
        output ready
    );
endinterface

// Result channel.
interface ham_pd_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] packed_color;

    modport source (output valid, packed_color, input ready);
    modport sink (input valid, packed_color, output ready);
endinterface

// Configuration write channel.
interface ham_pd_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/ham_palette_pixel_decoder.sv @@
// Top level of the HAM palette pixel decoder.
//
//  channel   role      transaction carries
//  item      sink      palette write or pixel (func, line_start, pixel, entry fields)
//  result    source    packed_color, one per decoded pixel
//  cfg       sink      register index and write data
//
// One item is taken every cycle while item.ready is high; a pixel result passes the
// registered palette read stage, the queue and the output register before it is valid.
// Palette writes give no transaction on result.
// The four-entry queue lets the front keep reading while the result side stalls;
// item.ready drops only when the queue and the read stage hold four pixels.
// Reset clears control state and the held color; the palette is undefined until written.
module ham_palette_pixel_decoder
    import ham_pd_pkg::*;
#(
    parameter int TABLE_ENTRIES = PD_TABLE_ENTRIES
)
(
    input  logic            clk,
    input  logic            rst_n,
    ham_pd_item_if.sink     item,
    ham_pd_result_if.source result,
    ham_pd_cfg_if.sink      cfg
);

    ham_cfg_t               regs;
    logic                   push;
    ham_entry_t             push_entry;
    logic                   pop;
    logic                   q_valid;
    ham_entry_t             q_entry;
    logic [QUEUE_CNT_W-1:0] q_count;

    // Configuration registers.
    ham_pd_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // Item intake, palette and pixel classification.
    ham_pd_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .regs       (regs),
        .q_count    (q_count),
        .push       (push),
        .push_entry (push_entry)
    );

    // Decoupling queue.
    ham_pd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .q_count    (q_count)
    );

    // Held color update and output packing.
    ham_pd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .pop     (pop),
        .regs    (regs),
        .result  (result)
    );

endmodule

@@ rtl/core/ham_pd_cfg.sv @@
// Configuration register file of the HAM palette pixel decoder.
module ham_pd_cfg
    import ham_pd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    ham_pd_cfg_if.sink    cfg,
    output ham_cfg_t      regs
);

    ham_cfg_t regs_reg;
    ham_cfg_t regs_next;

    // Writes are always taken.
    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // Decode the register index of a write transaction.
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_HAM_ENABLE:  regs_next.ham_enable  = cfg.data[0];
                CFG_PLANE_DEPTH: regs_next.plane_depth = cfg.data[3:0];
                CFG_RED_SHIFT:   regs_next.red_shift   = cfg.data[4:0];
                CFG_GREEN_SHIFT: regs_next.green_shift = cfg.data[4:0];
                CFG_BLUE_SHIFT:  regs_next.blue_shift  = cfg.data[4:0];
                CFG_ALPHA_SHIFT: regs_next.alpha_shift = cfg.data[4:0];
                default:         regs_next = regs_reg;
            endcase
        end
    end

    // Register storage with reset defaults.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.ham_enable  <= RST_HAM_ENABLE;
            regs_reg.plane_depth <= RST_PLANE_DEPTH;
            regs_reg.red_shift   <= RST_RED_SHIFT;
            regs_reg.green_shift <= RST_GREEN_SHIFT;
            regs_reg.blue_shift  <= RST_BLUE_SHIFT;
            regs_reg.alpha_shift <= RST_ALPHA_SHIFT;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

@@ rtl/core/ham_pd_front.sv @@
// Front end: accepts items, writes or reads the palette and classifies pixels.
module ham_pd_front
    import ham_pd_pkg::*;
#(
    parameter int TABLE_ENTRIES = PD_TABLE_ENTRIES
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    ham_pd_item_if.sink            item,
    input  ham_cfg_t               regs,
    input  logic [QUEUE_CNT_W-1:0] q_count,
    output logic                   push,
    output ham_entry_t             push_entry
);

    localparam int AW = $clog2(TABLE_ENTRIES);

    logic [31:0]   palette [TABLE_ENTRIES];
    logic [31:0]   rdata_reg;
    logic          s1_valid_reg;
    logic          s1_valid_next;
    ham_op_t       s1_op_reg;
    ham_op_t       op_next;

    logic          accept;
    logic          do_write;
    logic          do_read;
    logic [3:0]    depth;
    logic [7:0]    pix_m;
    logic [7:0]    low;
    logic [1:0]    mode;
    logic [15:0]   val_wide;
    logic [7:0]    lookup_idx;
    logic [11:0]   rem;
    logic [AW-1:0] rd_addr;

    // Room is reserved for the pixel still in the read stage.
    assign item.ready = ((4'(q_count) + 4'(s1_valid_reg)) < 4'(QUEUE_DEPTH));
    assign accept     = item.valid && item.ready;
    assign do_write   = accept && (item.func == FUNC_WRITE)
                        && (9'(item.entry_index) < 9'(TABLE_ENTRIES));
    assign do_read    = accept && (item.func == FUNC_DECODE);

    // Clamp the plane depth into its usable range.
    always_comb
    begin
        priority if (regs.plane_depth < DEPTH_MIN)
            depth = DEPTH_MIN;
        else if (regs.plane_depth > DEPTH_MAX)
            depth = DEPTH_MAX;
        else
            depth = regs.plane_depth;
    end

    // Split a hold-and-modify pixel into control code and low bits.
    always_comb
    begin
        pix_m    = item.pixel_value & 8'((9'd1 << depth) - 9'd1);
        mode     = 2'(pix_m >> (depth - 4'd2));
        low      = pix_m & 8'((9'd1 << (depth - 4'd2)) - 9'd1);
        val_wide = 16'(low) << (4'd10 - depth);
    end

    // Classify the pixel and pick the palette entry to read.
    always_comb
    begin
        op_next.line_start = item.line_start;
        op_next.val        = val_wide[7:0];
        if (regs.ham_enable)
        begin
            op_next.mode = mode;
            // A modify pixel needs entry 0 only when it starts a line.
            lookup_idx   = (mode == HAM_MODE_LOOKUP) ? low : 8'd0;
        end
        else
        begin
            op_next.mode = HAM_MODE_LOOKUP;
            lookup_idx   = item.pixel_value;
        end
    end

    // Index wrap by the table size as a short restoring reduction.
    always_comb
    begin
        rem = 12'(lookup_idx);
        for (int k = 3; k >= 0; k--)
        begin
            if (rem >= 12'(TABLE_ENTRIES << k))
                rem = rem - 12'(TABLE_ENTRIES << k);
        end
        rd_addr = rem[AW-1:0];
    end

    // Palette memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (do_write)
            palette[item.entry_index[AW-1:0]] <= {item.entry_alpha, item.entry_red,
                                                  item.entry_green, item.entry_blue};
        if (do_read)
        begin
            rdata_reg <= palette[rd_addr];
            s1_op_reg <= op_next;
        end
    end

    // Read stage valid flag.
    assign s1_valid_next = do_read;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // Hand the classified pixel to the queue.
    assign push             = s1_valid_reg;
    assign push_entry.op    = s1_op_reg;
    assign push_entry.rdata = rdata_reg;

endmodule

@@ rtl/core/ham_pd_queue.sv @@
// Short queue that decouples the front end from the color back end.
module ham_pd_queue
    import ham_pd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  ham_entry_t             push_entry,
    input  logic                   pop,
    output logic                   q_valid,
    output ham_entry_t             q_entry,
    output logic [QUEUE_CNT_W-1:0] q_count
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    ham_entry_t             slots [QUEUE_DEPTH];
    logic [PW-1:0]          wr_ptr_reg;
    logic [PW-1:0]          wr_ptr_next;
    logic [PW-1:0]          rd_ptr_reg;
    logic [PW-1:0]          rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;

    assign q_valid = (count_reg != '0);
    assign q_entry = slots[rd_ptr_reg];
    assign q_count = count_reg;

    // Pointer and fill level update.
    always_comb
    begin
        wr_ptr_next = push ? PW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? PW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = QUEUE_CNT_W'(count_reg + 1'b1);
        else if (pop && !push)
            count_next = QUEUE_CNT_W'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_entry;
    end

endmodule

@@ rtl/core/ham_pd_back.sv @@
// Back end: applies hold-and-modify to the held color and packs the result.
module ham_pd_back
    import ham_pd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  ham_entry_t      q_entry,
    output logic            pop,
    input  ham_cfg_t        regs,
    ham_pd_result_if.source result
);

    logic [31:0] held_reg;
    logic [31:0] held_next;
    logic [31:0] base;
    logic [31:0] color;
    logic [31:0] packed_next;
    logic [31:0] packed_reg;
    logic        out_valid_reg;
    logic        out_valid_next;

    // Take an entry whenever the output register is free or being drained.
    assign pop = q_valid && (!out_valid_reg || result.ready);

    // Build the new color from the held color or the palette word.
    always_comb
    begin
        base = q_entry.op.line_start ? q_entry.rdata : held_reg;
        unique case (q_entry.op.mode)
            HAM_MODE_LOOKUP: color = q_entry.rdata;
            HAM_MODE_BLUE:   color = {base[31:8], q_entry.op.val};
            HAM_MODE_RED:    color = {base[31:24], q_entry.op.val, base[15:0]};
            HAM_MODE_GREEN:  color = {base[31:16], q_entry.op.val, base[7:0]};
            default:         color = q_entry.rdata;
        endcase
        held_next = pop ? color : held_reg;
    end

    // Place each channel byte at its configured shift.
    always_comb
    begin
        packed_next = (32'(color[23:16]) << regs.red_shift)
                    | (32'(color[15:8])  << regs.green_shift)
                    | (32'(color[7:0])   << regs.blue_shift)
                    | (32'(color[31:24]) << regs.alpha_shift);
    end

    // Output register valid flag.
    always_comb
    begin
        if (pop)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            held_reg      <= held_next;
        end
    end

    // Result data register.
    always_ff @(posedge clk)
    begin
        if (pop)
            packed_reg <= packed_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.packed_color = packed_reg;

endmodule

@@ rtl/core/ham_pd_checker.sv @@
// Port-level checker of the HAM palette pixel decoder and its bind.
`include "ham_palette_pixel_decoder_assert.svh"

module ham_pd_checker
    import ham_pd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_ready,
    input  logic        item_func,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic [31:0] result_packed_color
);

    localparam logic [3:0] MAX_PENDING = 4'(QUEUE_DEPTH + 1);

    logic [3:0] pending_reg;
    logic [3:0] pending_next;
    logic       pix_in;
    logic       res_out;

    assign pix_in  = item_valid && item_ready && (item_func == FUNC_DECODE);
    assign res_out = result_valid && result_ready;

    // Pixels accepted whose result has not yet been delivered.
    always_comb
    begin
        pending_next = pending_reg;
        if (pix_in && !res_out)
            pending_next = 4'(pending_reg + 1'b1);
        else if (res_out && !pix_in)
            pending_next = 4'(pending_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    // A result is only delivered for a pixel that was taken.
    `HAM_ASSERT_IMPL(a_no_extra_result, clk, rst_n, res_out, pending_reg != 4'd0)
    // Pending pixels never exceed the queue depth plus the output register; the read stage shares the queue's room.
    `HAM_ASSERT_IMPL(a_pending_bound, clk, rst_n, 1'b1, pending_reg <= MAX_PENDING)
    // With nothing in flight the block must take items.
    `HAM_ASSERT_IMPL(a_ready_when_empty, clk, rst_n, pending_reg == 4'd0, item_ready)
    // A stalled result keeps its value.
    `HAM_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready,
        result_valid && $stable(result_packed_color))

endmodule

bind ham_palette_pixel_decoder ham_pd_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .item_valid          (item.valid),
    .item_ready          (item.ready),
    .item_func           (item.func),
    .result_valid        (result.valid),
    .result_ready        (result.ready),
    .result_packed_color (result.packed_color)
);
